// ----- rtl/b64sd_pkg.sv -----
`timescale 1ns / 1ps

package b64sd_pkg;

  // Padding character and the masks on the bits that padding drops
  localparam logic [7:0] PadChar      = 8'h3D;
  localparam logic [5:0] DropMaskPos2 = 6'h0F;
  localparam logic [5:0] DropMaskPos3 = 6'h03;
  localparam logic [5:0] SextetPlus   = 6'd62;
  localparam logic [5:0] SextetSlash  = 6'd63;

  // Padding progress within the current text
  typedef enum logic [1:0] {
    PAD_NONE = 2'd0,
    PAD_HALF = 2'd1,
    PAD_DONE = 2'd2
  } pad_e;

  typedef struct packed {
    logic       hit;
    logic [5:0] value;
  } sextet_t;

  // One decoder step result towards the output register
  typedef struct packed {
    logic       emit;
    logic       is_status;
    logic       ok;
    logic [7:0] data;
  } step_res_t;

  // Map one ASCII code onto its 6-bit alphabet value
  function automatic sextet_t sextet_of(input logic [7:0] ch);
    sextet_t s;
    logic [7:0] off;
    s = '0;
    off = '0;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      off = ch - 8'h41;
      s.hit = 1'b1;
      s.value = off[5:0];
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      off = ch - 8'h61 + 8'd26;
      s.hit = 1'b1;
      s.value = off[5:0];
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      off = ch - 8'h30 + 8'd52;
      s.hit = 1'b1;
      s.value = off[5:0];
    end else if (ch == 8'h2B) begin
      s.hit = 1'b1;
      s.value = SextetPlus;
    end else if (ch == 8'h2F) begin
      s.hit = 1'b1;
      s.value = SextetSlash;
    end
    return s;
  endfunction

endpackage

// ----- rtl/b64sd_core.sv -----
`timescale 1ns / 1ps

module b64sd_core import b64sd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] text_char_i,
  input  logic       end_of_text_i,
  output step_res_t  res_o
);

  logic [1:0] pos_q, pos_d;
  logic [5:0] held_q, held_d;
  pad_e       pad_q, pad_d;
  logic       fail_q, fail_d;
  sextet_t    sx;

  assign sx = sextet_of(text_char_i);

  // Work out the next decoder state and the beat it produces
  always_comb begin
    pos_d  = pos_q;
    held_d = held_q;
    pad_d  = pad_q;
    fail_d = fail_q;
    res_o  = '0;
    if (end_of_text_i) begin
      res_o.emit      = 1'b1;
      res_o.is_status = 1'b1;
      res_o.ok        = !fail_q && (pos_q == 2'd0) && (pad_q != PAD_HALF);
      pos_d  = '0;
      held_d = '0;
      pad_d  = PAD_NONE;
      fail_d = 1'b0;
    end else if (fail_q) begin
      // drop characters once the text has failed
    end else if (pad_q == PAD_DONE) begin
      fail_d = 1'b1;
    end else if (pad_q == PAD_HALF) begin
      if (text_char_i == PadChar) begin
        pad_d = PAD_DONE;
        pos_d = 2'd0;
      end else begin
        fail_d = 1'b1;
      end
    end else if (text_char_i == PadChar && pos_q[1]) begin
      if (pos_q == 2'd2) begin
        if ((held_q & DropMaskPos2) != '0) begin
          fail_d = 1'b1;
        end else begin
          pad_d = PAD_HALF;
          pos_d = 2'd3;
        end
      end else begin
        if ((held_q & DropMaskPos3) != '0) begin
          fail_d = 1'b1;
        end else begin
          pad_d = PAD_DONE;
          pos_d = 2'd0;
        end
      end
    end else if (!sx.hit) begin
      fail_d = 1'b1;
    end else begin
      unique case (pos_q)
        2'd0: begin
          pos_d = 2'd1;
        end
        2'd1: begin
          res_o.emit = 1'b1;
          res_o.data = {held_q, sx.value[5:4]};
          pos_d = 2'd2;
        end
        2'd2: begin
          res_o.emit = 1'b1;
          res_o.data = {held_q[3:0], sx.value[5:2]};
          pos_d = 2'd3;
        end
        default: begin
          res_o.emit = 1'b1;
          res_o.data = {held_q[1:0], sx.value};
          pos_d = 2'd0;
        end
      endcase
      held_d = sx.value;
    end
  end

  // Advance the state only when an item is stepped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      held_q <= '0;
      pad_q  <= PAD_NONE;
      fail_q <= 1'b0;
    end else if (step_i) begin
      pos_q  <= pos_d;
      held_q <= held_d;
      pad_q  <= pad_d;
      fail_q <= fail_d;
    end
  end

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && end_of_text_i |=> pos_q == 2'd0 && !fail_q && pad_q == PAD_NONE)
    else $error("state not cleared after end of text");

  a_half_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pad_q == PAD_HALF |-> pos_q == 2'd3)
    else $error("half padding outside fourth position");

  a_done_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pad_q == PAD_DONE |-> pos_q == 2'd0)
    else $error("closed padding with open quartet");

  a_fail_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fail_q && !end_of_text_i |-> !res_o.emit)
    else $error("byte emitted after failure");

endmodule

// ----- rtl/base64_strict_decoder.sv -----
`timescale 1ns / 1ps

// Strict base64 decoder, one character per input beat.
// Input channel: in_valid_i / in_ready_o carry text_char_i, or an end
// marker when end_of_text_i is high (text_char_i is then ignored).
// Output channel: out_valid_o / out_ready_i carry a decoded byte
// (is_status_o low) for the 2nd, 3rd and 4th character of each quartet,
// and one status beat (is_status_o high, decode_ok_o) per end marker.
// After any error no further bytes appear; the consumer drops the bytes
// of a text whose status says reject.
// A beat moves from the input register through the combinational
// decode step into the output register. Throughput: one character per
// cycle while the receiver takes beats, set by both registers and the step.
// Reset clears the quartet position, padding state and error flag, and
// empties both registers. When the receiver stalls, the output register
// holds its beat, the input register fills, and in_ready_o then drops
// until out_ready_i returns.
module base64_strict_decoder import b64sd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] text_char_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] data_byte_o,
  output logic       is_status_o,
  output logic       decode_ok_o
);

  logic       in_valid_q;
  logic [7:0] char_q;
  logic       end_q;
  logic       out_valid_q, out_valid_d;
  logic [7:0] byte_q;
  logic       status_q;
  logic       ok_q;
  logic       advance;
  logic       step;
  step_res_t  res;

  // Move on when the output register is free or being taken
  assign advance    = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  // Hold the accepted character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      char_q <= text_char_i;
      end_q  <= end_of_text_i;
    end
  end

  b64sd_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .text_char_i  (char_q),
    .end_of_text_i(end_q),
    .res_o        (res)
  );

  // Load a result beat or drain the taken one
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = step && res.emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res.emit) begin
      byte_q   <= res.data;
      status_q <= res.is_status;
      ok_q     <= res.ok;
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_byte_o = byte_q;
  assign is_status_o = status_q;
  assign decode_ok_o = ok_q;

  a_end_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && end_q |=> out_valid_q && status_q)
    else $error("end marker gave no status beat");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(char_q) && $stable(end_q))
    else $error("held character lost during stall");

  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(byte_q) &&
      $stable(status_q) && $stable(ok_q))
    else $error("output beat changed while stalled");

endmodule
